### rtl/core/orwa_pkg.sv
`default_nettype none

package orwa_pkg;

  localparam int unsigned OUT_W     = 10;
  localparam int unsigned LOW_NUM   = 9;
  localparam int unsigned HIGH_NUM  = 11;
  localparam int unsigned LIMIT_DEN = 10;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SUM  = 8'b0000_0010,
    S_MEAN = 8'b0000_0100,
    S_LOW  = 8'b0000_1000,
    S_HIGH = 8'b0001_0000,
    S_KEEP = 8'b0010_0000,
    S_AVG  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

### rtl/core/orwa_wmem.sv
`default_nettype none

module orwa_wmem #(
  parameter int DEPTH = 10,
  parameter int WIDTH = 10,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rdata_raw;
  logic             rdata_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_raw <= mem[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rdata_ok <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rdata_ok <= valid[raddr];
      end
    end
  end

  assign rdata = rdata_ok ? rdata_raw : '0;

endmodule

`default_nettype wire

### rtl/core/orwa_div.sv
`default_nettype none

module orwa_div #(
  parameter int W = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] quotient
);

  localparam int SW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [SW-1:0] step;
  logic          busy;
  logic [W:0]    trial;
  logic          fits;

  assign trial    = {rem, quo[W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= SW'(W);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // restoring step, one quotient bit per cycle
        rem  <= fits ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
        quo  <= {quo[W-2:0], fits};
        step <= step - SW'(1);
        if (step == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/outlier_rejecting_window_average_top.sv
// channel | signals                                         | carries
// in      | in_valid, in_ready, sample                      | sample transaction into the block
// out     | out_valid, out_ready, filtered_value, none_kept | one result per sample
//
// one sample at a time, since in_ready is high only in S_IDLE; sums are SUMW = SAMPLE_BITS +
// clog2(WINDOW+1) bits wide, and the divider is skipped when nothing is kept
// the work per sample is two read passes over the window memory (one entry per cycle, read data
// registered), three constant multiplies for mean and limits, each registered in its own state,
// and the restoring divider for the kept average (one quotient bit per cycle)
// synchronous reset empties the window at once through per-entry valid bits
// a new sample is taken while the previous result still waits; the next result stalls until then
`default_nettype none

module outlier_rejecting_window_average_top #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [9:0]                  sample,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [orwa_pkg::OUT_W-1:0]       filtered_value,
  output logic                             none_kept
);

  import orwa_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SUMW = SB + CW;

  // mean by reciprocal multiply, exact for every sum below 2**SUMW
  localparam int MPW       = 2 * SUMW + 1;
  localparam int WIN_SHIFT = SUMW + AW;
  localparam longint unsigned WIN_RECIP =
    ((64'd1 << WIN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  // limits by reciprocal multiply, exact for every mean times ratio below 2**(SB+4)
  localparam int LPW       = 2 * SB + 9;
  localparam int LIM_SHIFT = SB + 4 + $clog2(LIMIT_DEN);
  localparam longint unsigned LIM_RECIP =
    ((64'd1 << LIM_SHIFT) + 64'(LIMIT_DEN) - 64'd1) / 64'(LIMIT_DEN);

  state_t         state;
  logic [AW-1:0]  pos;
  logic [CW-1:0]  cnt;
  logic           rd_pend;
  logic           issue;
  logic           pass_end;
  logic           accept;
  logic [SB-1:0]  rdata;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] ksum;
  logic [CW-1:0]  kcnt;
  logic [SB-1:0]  mean;
  logic [SB-1:0]  low;
  logic [SB:0]    high;
  logic           keep;
  logic [OUT_W-1:0] res;
  logic           res_none;
  logic [MPW-1:0] mean_prod;
  logic [LPW-1:0] low_prod;
  logic [LPW-1:0] high_prod;

  logic            div_start;
  logic [SUMW-1:0] div_dividend;
  logic [SUMW-1:0] div_divisor;
  logic            div_done;
  logic [SUMW-1:0] div_quo;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = ((state == S_SUM) || (state == S_KEEP)) && (cnt != CW'(WINDOW));
  assign pass_end = ((state == S_SUM) || (state == S_KEEP)) && (cnt == CW'(WINDOW))
                    && !rd_pend;
  assign keep     = (rdata >= low) && ((SB + 1)'(rdata) <= high);

  assign mean_prod = MPW'(sum) * MPW'(WIN_RECIP);
  assign low_prod  = LPW'(mean) * LPW'(64'(LOW_NUM) * LIM_RECIP);
  assign high_prod = LPW'(mean) * LPW'(64'(HIGH_NUM) * LIM_RECIP);

  orwa_wmem #(
    .DEPTH (WINDOW),
    .WIDTH (SB),
    .AW    (AW)
  ) u_wmem (
    .clk   (clk),
    .rst   (rst),
    .we    (accept),
    .waddr (pos),
    .wdata (SB'(sample)),
    .re    (issue),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  orwa_div #(
    .W (SUMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign div_start    = (state == S_KEEP) && pass_end && (kcnt != '0);
  assign div_dividend = ksum;
  assign div_divisor  = SUMW'(kcnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos   <= (pos == AW'(WINDOW - 1)) ? '0 : pos + AW'(1);
            cnt   <= '0;
            sum   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (rd_pend) begin
            sum <= sum + SUMW'(rdata);
          end
          if (pass_end) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          mean  <= SB'(mean_prod >> WIN_SHIFT);
          state <= S_LOW;
        end
        S_LOW: begin
          low   <= SB'(low_prod >> LIM_SHIFT);
          state <= S_HIGH;
        end
        S_HIGH: begin
          high  <= (SB + 1)'(high_prod >> LIM_SHIFT);
          cnt   <= '0;
          ksum  <= '0;
          kcnt  <= '0;
          state <= S_KEEP;
        end
        S_KEEP: begin
          if (rd_pend && keep) begin
            ksum <= ksum + SUMW'(rdata);
            kcnt <= kcnt + CW'(1);
          end
          if (pass_end) begin
            if (kcnt == '0) begin
              res      <= '0;
              res_none <= 1'b1;
              state    <= S_OUT;
            end else begin
              state <= S_AVG;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            res      <= div_quo[OUT_W-1:0];
            res_none <= 1'b0;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            filtered_value <= res;
            none_kept      <= res_none;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/orwa_checker.sv
`default_nettype none

module orwa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [9:0] sample,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [9:0] filtered_value,
  input wire logic       none_kept
);

  // one sample in flight: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  // empty keep set always reports zero
  a_none_kept_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_kept |-> filtered_value == 10'd0)
    else $error("none_kept with nonzero value");

  // out_valid never rises directly after an input transaction
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared one cycle after input");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_value) && $stable(none_kept))
    else $error("stalled result changed");

endmodule

bind outlier_rejecting_window_average_top orwa_checker u_orwa_checker (.*);

`default_nettype wire

### tb/outlier_rejecting_window_average_top_tb.sv
`timescale 1ns / 1ps

class trimmed_mean_scoreboard;
  localparam int unsigned SLOTS = 10;

  typedef struct packed {
    logic [9:0] value;
    logic       nothing_kept;
  } avg_result_t;

  logic [9:0]  window [SLOTS];
  int unsigned wr_pos;
  avg_result_t expected_avgs [$];
  int unsigned errors;

  function new();
    foreach (window[i]) window[i] = '0;
    wr_pos = 0;
    errors = 0;
  endfunction

  function void note_sample(logic [9:0] v);
    int unsigned sum;
    int unsigned mean;
    int unsigned lo;
    int unsigned hi;
    int unsigned kept_sum;
    int unsigned kept_cnt;
    avg_result_t r;
    if (wr_pos >= SLOTS) wr_pos = 0;
    window[wr_pos] = v;
    wr_pos++;
    if (wr_pos >= SLOTS) wr_pos = 0;
    sum = 0;
    foreach (window[i]) sum += window[i];
    mean = sum / SLOTS;
    lo = (mean * 9) / 10;
    hi = (mean * 11) / 10;
    kept_sum = 0;
    kept_cnt = 0;
    foreach (window[i]) begin
      if (window[i] >= lo && window[i] <= hi) begin
        kept_sum += window[i];
        kept_cnt++;
      end
    end
    if (kept_cnt == 0) begin
      r.value = '0;
      r.nothing_kept = 1'b1;
    end else begin
      r.value = 10'(kept_sum / kept_cnt);
      r.nothing_kept = 1'b0;
    end
    expected_avgs.push_back(r);
  endfunction

  function void check_result(logic [9:0] value, logic nothing_kept);
    avg_result_t r;
    if (expected_avgs.size() == 0) begin
      $error("unexpected result: filtered_value=%0d none_kept=%0b", value, nothing_kept);
      errors++;
      return;
    end
    r = expected_avgs.pop_front();
    if (value !== r.value) begin
      $error("filtered_value: expected %0d, actual %0d", r.value, value);
      errors++;
    end
    if (nothing_kept !== r.nothing_kept) begin
      $error("none_kept: expected %0b, actual %0b", r.nothing_kept, nothing_kept);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_avgs.size();
  endfunction
endclass

module outlier_rejecting_window_average_top_tb;
  import orwa_pkg::*;

  localparam int RANDOM_SAMPLES = 700;
  localparam int HOLD_OFF_AT    = 200;
  localparam int HOLD_OFF_LEN   = 500;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [9:0]          sample;
  logic                out_valid;
  logic                out_ready;
  logic [OUT_W-1:0]    filtered_value;
  logic                none_kept;

  trimmed_mean_scoreboard sb;
  bit send_steady;
  bit recv_steady;

  outlier_rejecting_window_average_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .none_kept      (none_kept)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_sample(input logic [9:0] v);
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v);
  endtask

  task automatic send_random_samples(input int count);
    int          done;
    int          seg_len;
    int          base;
    int          spread;
    int          s;
    done = 0;
    while (done < count) begin
      seg_len = $urandom_range(10, 40);
      case ($urandom_range(0, 9))
        0:       base = $urandom_range(0, 15);
        1:       base = $urandom_range(1000, 1023);
        default: base = $urandom_range(0, 1023);
      endcase
      spread = base / 16 + 2;
      if ($urandom_range(0, 9) < 3) begin
        // unstructured noise
        repeat (seg_len) begin
          send_sample(10'($urandom_range(0, 1023)));
          done++;
        end
      end else begin
        // steady level with small jitter and occasional spikes
        repeat (seg_len) begin
          if ($urandom_range(0, 9) == 0) begin
            s = $urandom_range(0, 1023);
          end else begin
            s = base + $urandom_range(0, 2 * spread) - spread;
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
          end
          send_sample(10'(s));
          done++;
        end
      end
    end
  endtask

  initial begin
    logic [9:0] directed [$];
    sb = new();
    rst      <= 1'b1;
    in_valid <= 1'b0;
    sample   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // all-zero window, then full-scale samples; with half the window at full scale nothing is kept
    directed.push_back(10'd0);
    repeat (5) directed.push_back(10'd1023);
    repeat (5) directed.push_back(10'd1023);
    directed.push_back(10'h155);
    directed.push_back(10'h2aa);
    // samples sitting exactly on both limits
    repeat (8) directed.push_back(10'd100);
    directed.push_back(10'd90);
    directed.push_back(10'd110);
    directed.push_back(10'd89);
    directed.push_back(10'd111);
    foreach (directed[i]) send_sample(directed[i]);

    send_random_samples(RANDOM_SAMPLES);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    int results;
    out_ready <= 1'b0;
    results = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
      gap = recv_steady ? 0 : $urandom_range(0, 8);
      if (results == HOLD_OFF_AT) gap = HOLD_OFF_LEN;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(filtered_value, none_kept);
      results++;
    end
  end

endmodule

### sim.f
rtl/core/orwa_pkg.sv
rtl/core/orwa_wmem.sv
rtl/core/orwa_div.sv
rtl/core/outlier_rejecting_window_average_top.sv
rtl/core/orwa_checker.sv
tb/outlier_rejecting_window_average_top_tb.sv
